FILE: src/tsvf_pkg.sv
// Shared types and constants for the trapezoidal state variable filter.
// Holds register codes, response modes, sequencer states and MAC control.
// No dependencies.
package tsvf_pkg;

   // Coefficient format and digit-serial slicing
   localparam int COEF_W      = 24;
   localparam int DIGIT_W     = 8;
   localparam int COEF_DIGITS = COEF_W / DIGIT_W;
   localparam int DIG_CNT_W   = $clog2(COEF_DIGITS);

   // Integrator state, intermediate and accumulator widths
   localparam int STATE_W = 32;
   localparam int MID_W   = 40;
   localparam int ACC_W   = COEF_W + MID_W + 2;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int MODE_W      = 2;

   localparam logic [COEF_W-1:0] A1_RESET = 24'd3694180;
   localparam logic [COEF_W-1:0] A2_RESET = 24'd242124;
   localparam logic [COEF_W-1:0] A3_RESET = 24'd15870;
   localparam logic [COEF_W-1:0] K_RESET  = 24'd8388608;

   typedef logic [COEF_W-1:0] tsvf_coef_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOWPASS  = 2'd0,
      MODE_HIGHPASS = 2'd1,
      MODE_BANDPASS = 2'd2,
      MODE_NOTCH    = 2'd3
   } tsvf_mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MODE = 3'd0,
      REG_A1   = 3'd1,
      REG_A2   = 3'd2,
      REG_A3   = 3'd3,
      REG_K    = 3'd4
   } tsvf_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_V1A,
      ST_V1B,
      ST_RND_V1,
      ST_V2A,
      ST_V2B,
      ST_RND_V2,
      ST_SUM_V2,
      ST_KV,
      ST_RND_KV,
      ST_OUT
   } tsvf_state_type;

   // Multiply-accumulate step control
   typedef struct packed {
      logic en;     // perform one digit step
      logic first;  // first digit: take coefficient and operand from inputs
      logic clear;  // with first: start a new sum
   } tsvf_mac_ctrl_type;

endpackage

FILE: src/tsvf_if.sv
// Stream interfaces for sample requests and filtered responses.
// Valid/ready handshake; payload width follows SAMPLE_BITS. No dependencies.
interface tsvf_req_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface tsvf_rsp_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic                          clipped;

   modport source (output valid, output sample_out, output clipped, input ready);
   modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

FILE: src/tsvf_mac.sv
// Digit-serial multiply-accumulate: unsigned coefficient times signed operand.
// Consumes one 8-bit coefficient digit per step via shift registers. Uses tsvf_pkg.
module tsvf_mac
   import tsvf_pkg::*;
(
   input  logic                    clock,
   input  tsvf_mac_ctrl_type       ctrl,
   input  tsvf_coef_type           coef,
   input  logic signed [MID_W-1:0] opnd,
   output logic signed [ACC_W-1:0] acc
);

   logic [COEF_W-1:0]        coef_sr_ff, coef_sr_in, coef_src;
   logic signed [ACC_W-1:0]  opnd_sr_ff, opnd_sr_in, opnd_src;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, acc_base, prod;
   logic [DIGIT_W-1:0]       digit;

   // Select digit source, form the partial product and advance the shifters
   always_comb begin
      coef_src   = ctrl.first ? coef : coef_sr_ff;
      opnd_src   = ctrl.first ? ACC_W'(opnd) : opnd_sr_ff;
      digit      = coef_src[DIGIT_W-1:0];
      prod       = $signed({1'b0, digit}) * opnd_src;
      acc_base   = (ctrl.first && ctrl.clear) ? '0 : acc_ff;
      acc_in     = acc_base + prod;
      coef_sr_in = coef_src >> DIGIT_W;
      opnd_sr_in = opnd_src <<< DIGIT_W;
   end

   // Hold between steps
   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         coef_sr_ff <= coef_sr_in;
         opnd_sr_ff <= opnd_sr_in;
         acc_ff     <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

FILE: src/trapezoidal_state_variable_filter.sv
// Trapezoidal state variable filter, top level; uses tsvf_pkg, tsvf_if, tsvf_mac.
// An accepted sample steps through V1A, V1B, RND_V1, V2A, V2B, RND_V2, SUM_V2, KV,
//   RND_KV and OUT; a new sample is taken only from idle. Five products of three
//   8-bit coefficient digits each run on one shared digit-serial MAC.
// Reset (synchronous, active high): integrators cleared, sequencer idle, no
//   response pending, coefficient and mode registers back to defaults.
module trapezoidal_state_variable_filter
   import tsvf_pkg::*;
#(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 22
) (
   input  logic                   clock,
   input  logic                   reset,
   tsvf_req_if.sink               req_bus,
   tsvf_rsp_if.source             rsp_bus,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]      csr_wdata
);

   localparam int V3_W     = STATE_W + 1;
   localparam int DIFF_W   = MID_W + 1;
   localparam int ST_SUM_W = MID_W + 2;
   localparam int RES_W    = ACC_W + 1;

   localparam logic signed [ACC_W-1:0] ROUND_HALF =
      {{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] ROUND_HALF_LESS = ROUND_HALF - ACC_W'(1);

   localparam logic signed [MID_W-1:0]   MID_MAX    = {1'b0, {(MID_W-1){1'b1}}};
   localparam logic signed [MID_W-1:0]   MID_MIN    = {1'b1, {(MID_W-1){1'b0}}};
   localparam logic signed [STATE_W-1:0] STATE_MAX  = {1'b0, {(STATE_W-1){1'b1}}};
   localparam logic signed [STATE_W-1:0] STATE_MIN  = {1'b1, {(STATE_W-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // Configuration registers
   tsvf_mode_type mode_ff;
   tsvf_coef_type a1_ff, a2_ff, a3_ff, k_ff;

   // Sequencer
   tsvf_state_type         state_ff, state_in;
   logic [DIG_CNT_W-1:0]   dig_ff, dig_in;
   logic                   last_dig;
   logic                   req_acc, out_free;

   // Datapath
   logic signed [SAMPLE_BITS-1:0] v0_ff;
   logic signed [V3_W-1:0]        v3_ff;
   logic signed [STATE_W-1:0]     ic1_ff, ic2_ff;
   logic signed [MID_W-1:0]       v1_ff, v2_ff;
   logic signed [ACC_W-1:0]       rv2_ff, kv1_ff;
   logic signed [DIFF_W-1:0]      diff_ff;
   logic                          clip_ff, clip_in;

   // Output register
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic                          rsp_clip_ff;

   // MAC interface
   tsvf_mac_ctrl_type       mac_ctrl;
   tsvf_coef_type           mac_coef;
   logic signed [MID_W-1:0] mac_opnd;
   logic signed [ACC_W-1:0] mac_acc;

   // Rounding and saturation
   logic signed [ACC_W-1:0]       rnd_bias, rnd;
   logic                          v1_fits;
   logic signed [MID_W-1:0]       v1_sat;
   logic signed [ACC_W-1:0]       v2_sum;
   logic                          v2_fits;
   logic signed [MID_W-1:0]       v2_sat;
   logic signed [ST_SUM_W-1:0]    st1_sum, st2_sum;
   logic                          st1_fits, st2_fits;
   logic signed [STATE_W-1:0]     st1_sat, st2_sat;
   logic signed [DIFF_W-1:0]      diff;
   logic signed [RES_W-1:0]       res;
   logic                          res_fits;
   logic signed [SAMPLE_BITS-1:0] res_sat;

   assign req_acc  = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign last_dig = (dig_ff == DIG_CNT_W'(COEF_DIGITS - 1));

   // Configuration writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_LOWPASS;
         a1_ff   <= A1_RESET;
         a2_ff   <= A2_RESET;
         a3_ff   <= A3_RESET;
         k_ff    <= K_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MODE: mode_ff <= tsvf_mode_type'(csr_wdata[MODE_W-1:0]);
            REG_A1:   a1_ff   <= csr_wdata;
            REG_A2:   a2_ff   <= csr_wdata;
            REG_A3:   a3_ff   <= csr_wdata;
            REG_K:    k_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_acc) state_in = ST_V1A;
         ST_V1A:    if (last_dig) state_in = ST_V1B;
         ST_V1B:    if (last_dig) state_in = ST_RND_V1;
         ST_RND_V1: state_in = ST_V2A;
         ST_V2A:    if (last_dig) state_in = ST_V2B;
         ST_V2B:    if (last_dig) state_in = ST_RND_V2;
         ST_RND_V2: state_in = ST_SUM_V2;
         ST_SUM_V2: state_in = ST_KV;
         ST_KV:     if (last_dig) state_in = ST_RND_KV;
         ST_RND_KV: state_in = ST_OUT;
         ST_OUT:    if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: handshake and MAC operand selection
   always_comb begin
      req_bus.ready  = 1'b0;
      mac_ctrl.en    = 1'b0;
      mac_ctrl.clear = 1'b0;
      mac_coef       = a1_ff;
      mac_opnd       = MID_W'(ic1_ff);
      unique case (state_ff)
         ST_IDLE: req_bus.ready = 1'b1;
         ST_V1A: begin
            mac_ctrl.en    = 1'b1;
            mac_ctrl.clear = 1'b1;
            mac_coef       = a1_ff;
            mac_opnd       = MID_W'(ic1_ff);
         end
         ST_V1B: begin
            mac_ctrl.en = 1'b1;
            mac_coef    = a2_ff;
            mac_opnd    = MID_W'(v3_ff);
         end
         ST_V2A: begin
            mac_ctrl.en    = 1'b1;
            mac_ctrl.clear = 1'b1;
            mac_coef       = a2_ff;
            mac_opnd       = MID_W'(ic1_ff);
         end
         ST_V2B: begin
            mac_ctrl.en = 1'b1;
            mac_coef    = a3_ff;
            mac_opnd    = MID_W'(v3_ff);
         end
         ST_KV: begin
            mac_ctrl.en    = 1'b1;
            mac_ctrl.clear = 1'b1;
            mac_coef       = k_ff;
            mac_opnd       = v1_ff;
         end
         default: ;
      endcase
      mac_ctrl.first = (dig_ff == '0);
      dig_in = (mac_ctrl.en && !last_dig) ? dig_ff + DIG_CNT_W'(1) : '0;
   end

   tsvf_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .coef  (mac_coef),
      .opnd  (mac_opnd),
      .acc   (mac_acc)
   );

   // Round the product sum to nearest, ties away from zero
   always_comb begin
      rnd_bias = mac_acc[ACC_W-1] ? ROUND_HALF_LESS : ROUND_HALF;
      rnd      = (mac_acc + rnd_bias) >>> COEF_FRAC_BITS;
   end

   // Saturate intermediates and new states
   always_comb begin
      v1_fits = (&rnd[ACC_W-1:MID_W-1]) || !(|rnd[ACC_W-1:MID_W-1]);
      v1_sat  = v1_fits ? rnd[MID_W-1:0] : (rnd[ACC_W-1] ? MID_MIN : MID_MAX);

      v2_sum  = ACC_W'(ic2_ff) + rv2_ff;
      v2_fits = (&v2_sum[ACC_W-1:MID_W-1]) || !(|v2_sum[ACC_W-1:MID_W-1]);
      v2_sat  = v2_fits ? v2_sum[MID_W-1:0] : (v2_sum[ACC_W-1] ? MID_MIN : MID_MAX);

      st1_sum  = (ST_SUM_W'(v1_ff) <<< 1) - ST_SUM_W'(ic1_ff);
      st1_fits = (&st1_sum[ST_SUM_W-1:STATE_W-1]) || !(|st1_sum[ST_SUM_W-1:STATE_W-1]);
      st1_sat  = st1_fits ? st1_sum[STATE_W-1:0]
                          : (st1_sum[ST_SUM_W-1] ? STATE_MIN : STATE_MAX);

      st2_sum  = (ST_SUM_W'(v2_ff) <<< 1) - ST_SUM_W'(ic2_ff);
      st2_fits = (&st2_sum[ST_SUM_W-1:STATE_W-1]) || !(|st2_sum[ST_SUM_W-1:STATE_W-1]);
      st2_sat  = st2_fits ? st2_sum[STATE_W-1:0]
                          : (st2_sum[ST_SUM_W-1] ? STATE_MIN : STATE_MAX);

      diff = DIFF_W'(v0_ff) - DIFF_W'(v2_ff);
   end

   // Select the response and saturate to the sample width
   always_comb begin
      case (mode_ff)
         MODE_HIGHPASS: res = RES_W'(diff_ff) - RES_W'(kv1_ff);
         MODE_BANDPASS: res = RES_W'(v1_ff);
         MODE_NOTCH:    res = RES_W'(v0_ff) - RES_W'(kv1_ff);
         default:       res = RES_W'(v2_ff);
      endcase
      res_fits = (&res[RES_W-1:SAMPLE_BITS-1]) || !(|res[RES_W-1:SAMPLE_BITS-1]);
      res_sat  = res_fits ? res[SAMPLE_BITS-1:0]
                          : (res[RES_W-1] ? SAMPLE_MIN : SAMPLE_MAX);
   end

   // Collect saturation events for this transaction
   always_comb begin
      clip_in = clip_ff;
      case (state_ff)
         ST_IDLE:   if (req_acc) clip_in = 1'b0;
         ST_RND_V1: clip_in = clip_ff || !v1_fits;
         ST_SUM_V2: clip_in = clip_ff || !v2_fits || !st1_fits;
         ST_RND_KV: clip_in = clip_ff || !st2_fits;
         default: ;
      endcase
   end

   // Control state, integrators and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dig_ff       <= '0;
         ic1_ff       <= '0;
         ic2_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         dig_ff   <= dig_in;
         if (state_ff == ST_SUM_V2) begin
            ic1_ff <= st1_sat;
         end
         if (state_ff == ST_RND_KV) begin
            ic2_ff <= st2_sat;
         end
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      clip_ff <= clip_in;
      if (req_acc) begin
         v0_ff <= req_bus.sample_in;
         v3_ff <= V3_W'(req_bus.sample_in) - V3_W'(ic2_ff);
      end
      if (state_ff == ST_RND_V1) begin
         v1_ff <= v1_sat;
      end
      if (state_ff == ST_RND_V2) begin
         rv2_ff <= rnd;
      end
      if (state_ff == ST_SUM_V2) begin
         v2_ff <= v2_sat;
      end
      if (state_ff == ST_RND_KV) begin
         kv1_ff  <= rnd;
         diff_ff <= diff;
      end
      if (state_ff == ST_OUT && out_free) begin
         rsp_sample_ff <= res_sat;
         rsp_clip_ff   <= clip_ff || !res_fits;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.sample_out = rsp_sample_ff;
   assign rsp_bus.clipped    = rsp_clip_ff;

   // Digit counter rests at zero outside multiply phases
   a_dig_rest: assert property (@(posedge clock) disable iff (reset)
      !mac_ctrl.en |-> dig_ff == '0)
      else $error("digit counter not at rest outside a multiply phase");

   // Accepted sample starts the first product with a clean clip flag
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == ST_V1A) && !clip_ff)
      else $error("accepted sample did not start the multiply sequence");

   // A finished sample waits while the previous response is stalled
   a_out_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) && rsp_valid_ff && !rsp_bus.ready |=> state_ff == ST_OUT)
      else $error("result dropped while response register was occupied");

   // A response appears only from the output step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("response raised outside the output step");

endmodule

FILE: tb/sv/tsvf_response_checker.sv
// Response checker for the trapezoidal state variable filter: predicts each
// filtered sample from the accepted input samples and register writes.
// Depends on tsvf_pkg and the tsvf_req_if / tsvf_rsp_if interfaces.
`timescale 1ns / 1ps
module tsvf_response_checker
   import tsvf_pkg::*;
#(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 22
) (
   input  logic                   clock,
   input  logic                   reset,
   tsvf_req_if                    req_mon,
   tsvf_rsp_if                    rsp_mon,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]      csr_wdata,
   output int                     outstanding,
   output int                     mismatches
);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          clipped;
   } filtered_sample_type;

   // Shadow of the filter's registers and integrators
   tsvf_mode_type       resp_mode;
   tsvf_coef_type       coef_a1;
   tsvf_coef_type       coef_a2;
   tsvf_coef_type       coef_a3;
   tsvf_coef_type       damping_k;
   longint              first_integ;
   longint              second_integ;
   filtered_sample_type filtered_q[$];
   int                  error_total;

   // Shift a coefficient product down to sample scale, ties away from zero
   function automatic longint round_coef(input longint acc);
      longint unsigned mag;
      mag = (acc < 0) ? -acc : acc;
      mag = (mag + (64'd1 << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;
      return (acc < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic bit overflows(input longint x, input int bits);
      longint hi;
      hi = (longint'(1) << (bits - 1)) - 1;
      return (x > hi) || (x < -hi - 1);
   endfunction

   function automatic longint clamp_to(input longint x, input int bits);
      longint hi;
      hi = (longint'(1) << (bits - 1)) - 1;
      if (x > hi) return hi;
      if (x < -hi - 1) return -hi - 1;
      return x;
   endfunction

   // One filter step: advance both integrators and form the selected response
   function automatic filtered_sample_type filter_step(
         input logic signed [SAMPLE_BITS-1:0] sample);
      longint              v0, v1, v2, v3, ic1, ic2, next1, next2, kv1, res;
      bit                  clip;
      filtered_sample_type out;
      clip = 1'b0;
      v0   = longint'(sample);
      ic1  = first_integ;
      ic2  = second_integ;
      v3   = v0 - ic2;

      v1   = round_coef(longint'(coef_a1) * ic1 + longint'(coef_a2) * v3);
      clip |= overflows(v1, MID_W);
      v1   = clamp_to(v1, MID_W);
      v2   = ic2 + round_coef(longint'(coef_a2) * ic1 + longint'(coef_a3) * v3);
      clip |= overflows(v2, MID_W);
      v2   = clamp_to(v2, MID_W);

      next1 = 2 * v1 - ic1;
      next2 = 2 * v2 - ic2;
      clip |= overflows(next1, STATE_W) | overflows(next2, STATE_W);
      first_integ  = clamp_to(next1, STATE_W);
      second_integ = clamp_to(next2, STATE_W);

      kv1 = round_coef(longint'(damping_k) * v1);
      case (resp_mode)
         MODE_HIGHPASS: res = v0 - kv1 - v2;
         MODE_BANDPASS: res = v1;
         MODE_NOTCH:    res = v0 - kv1;
         default:       res = v2;
      endcase
      clip |= overflows(res, SAMPLE_BITS);
      res = clamp_to(res, SAMPLE_BITS);

      out.sample_out = res[SAMPLE_BITS-1:0];
      out.clipped    = clip;
      return out;
   endfunction

   always @(posedge clock) begin : watch
      filtered_sample_type want;
      if (reset) begin
         resp_mode    = MODE_LOWPASS;
         coef_a1      = A1_RESET;
         coef_a2      = A2_RESET;
         coef_a3      = A3_RESET;
         damping_k    = K_RESET;
         first_integ  = 0;
         second_integ = 0;
         filtered_q.delete();
      end else begin
         // Track register writes; unknown indexes are dropped
         if (csr_we) begin
            case (csr_index)
               REG_MODE: resp_mode = tsvf_mode_type'(csr_wdata[MODE_W-1:0]);
               REG_A1:   coef_a1   = csr_wdata;
               REG_A2:   coef_a2   = csr_wdata;
               REG_A3:   coef_a3   = csr_wdata;
               REG_K:    damping_k = csr_wdata;
               default: ;
            endcase
         end

         // Compare each response transaction with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (filtered_q.size() == 0) begin
               $error("response with no sample pending: sample_out %0d clipped %0b",
                      rsp_mon.sample_out, rsp_mon.clipped);
               error_total++;
            end else begin
               want = filtered_q.pop_front();
               if (rsp_mon.sample_out !== want.sample_out) begin
                  $error("sample_out mismatch: expected %0d, actual %0d",
                         want.sample_out, rsp_mon.sample_out);
                  error_total++;
               end
               if (rsp_mon.clipped !== want.clipped) begin
                  $error("clipped mismatch: expected %0b, actual %0b",
                         want.clipped, rsp_mon.clipped);
                  error_total++;
               end
            end
         end

         // Predict the response for each request transaction
         if (req_mon.valid && req_mon.ready)
            filtered_q.push_back(filter_step(req_mon.sample_in));
      end
      outstanding <= filtered_q.size();
      mismatches  <= error_total;
   end

endmodule

FILE: tb/sv/trapezoidal_state_variable_filter_tb.sv
// Testbench top for the trapezoidal state variable filter: drives samples and
// register settings, stalls the response side, and reports the verdict.
// Depends on tsvf_pkg, tsvf_if, the filter RTL and tsvf_response_checker.
`timescale 1ns / 1ps
module trapezoidal_state_variable_filter_tb
   import tsvf_pkg::*;
;
   localparam int SAMPLE_BITS    = 24;
   localparam int COEF_FRAC_BITS = 22;
   localparam int IDLE_PERCENT   = 8;
   localparam int RANDOM_PHASES  = 9;
   localparam int PHASE_ITEMS    = 50;
   localparam int QUIET_FIRST    = 150;   // no idling on either side in this span
   localparam int QUIET_LAST     = 250;
   localparam int HOLD_AT        = 60;    // response count that starts the long stall
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES    = 40;

   localparam logic [COEF_W-1:0]        COEF_MAX     = '1;
   localparam real                      COEF_ONE     = real'(1 << COEF_FRAC_BITS);
   localparam logic [CSR_INDEX_W-1:0]   UNUSED_INDEX = 3'd5;  // first index with no register
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [COEF_W-1:0]      csr_wdata;
   int                     outstanding;
   int                     mismatches;
   int                     items_sent;

   tsvf_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   tsvf_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_bus ();

   trapezoidal_state_variable_filter #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   tsvf_response_checker #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) filter_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .outstanding(outstanding),
      .mismatches (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one sample, with a random idle gap ahead of it outside the quiet span
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
      bit quiet;
      quiet = (items_sent >= QUIET_FIRST) && (items_sent < QUIET_LAST);
      while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.sample_in <= value;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   // Drop valid and hold until every predicted response has come back
   task automatic wait_drained;
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [COEF_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [COEF_W-1:0] mode_word,
                                input logic [COEF_W-1:0] a1, a2, a3, k,
                                input bit poke_unused);
      int idx;
      write_register(REG_MODE, mode_word);
      write_register(REG_A1, a1);
      write_register(REG_A2, a2);
      write_register(REG_A3, a3);
      write_register(REG_K, k);
      if (poke_unused)
         for (idx = int'(UNUSED_INDEX); idx < (1 << CSR_INDEX_W); idx++)
            write_register(CSR_INDEX_W'(idx), COEF_W'($urandom()));
      csr_we <= 1'b0;
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
      case ($urandom_range(9))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2, 3:    return SAMPLE_BITS'(int'($urandom_range(2000)) - 1000);
         default: return SAMPLE_BITS'($urandom());
      endcase
   endfunction

   // Response side: random stalls, one long hold-off, one span with no stalls
   initial begin : response_sink
      int taken;
      int hold_left;
      bit hold_done;
      taken     = 0;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) taken++;
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!hold_done && taken >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else if (taken >= QUIET_FIRST && taken < QUIET_LAST) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // End the run when no transaction has moved for too long
   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (stalled < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || csr_we)
            stalled = 0;
         else
            stalled++;
      end
      $display("trapezoidal_state_variable_filter verification failed");
      $finish;
   end

   initial begin : stimulus
      int                phase;
      int                item;
      int                kind;
      real               fc, g, k, a1r;
      logic [COEF_W-1:0] a1, a2, a3, kq;
      items_sent        = 0;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.sample_in <= '0;
      csr_we            <= 1'b0;
      csr_index         <= '0;
      csr_wdata         <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default lowpass: zero, full-scale steps and the smallest nonzero values
      send_sample('0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_BITS'(1));
      send_sample(SAMPLE_BITS'(-1));
      send_sample('0);

      // Largest coefficients, notch: integrators and output saturate
      wait_drained;
      load_settings(COEF_W'(MODE_NOTCH), COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 1'b0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample('0);

      // Zero coefficients, bandpass given in a word with all upper bits set,
      // plus writes to indexes that hold no register
      wait_drained;
      load_settings({{(COEF_W-MODE_W){1'b1}}, MODE_BANDPASS}, '0, '0, '0, '0, 1'b1);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample('0);
      send_sample(SAMPLE_BITS'(5));

      // Default coefficients, highpass
      wait_drained;
      load_settings(COEF_W'(MODE_HIGHPASS), A1_RESET, A2_RESET, A3_RESET, K_RESET, 1'b0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample('0);

      // Random phases: mostly designed coefficient sets, some raw and extreme
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drained;
         kind = $urandom_range(9);
         if (kind < 6) begin
            fc  = real'($urandom_range(4000, 1)) / 10000.0;
            k   = real'($urandom_range(2000, 50)) / 1000.0;
            g   = $tan(3.14159265358979 * fc);
            a1r = 1.0 / (1.0 + g * (g + k));
            a1  = COEF_W'($rtoi(a1r * COEF_ONE));
            a2  = COEF_W'($rtoi(g * a1r * COEF_ONE));
            a3  = COEF_W'($rtoi(g * g * a1r * COEF_ONE));
            kq  = COEF_W'($rtoi(k * COEF_ONE));
         end else if (kind < 8) begin
            a1 = COEF_W'($urandom());
            a2 = COEF_W'($urandom());
            a3 = COEF_W'($urandom());
            kq = COEF_W'($urandom());
         end else begin
            a1 = $urandom_range(1) ? COEF_MAX : '0;
            a2 = $urandom_range(1) ? COEF_MAX : '0;
            a3 = $urandom_range(1) ? COEF_MAX : '0;
            kq = $urandom_range(1) ? COEF_MAX : '0;
         end
         load_settings(COEF_W'($urandom()), a1, a2, a3, kq, $urandom_range(3) == 0);
         for (item = 0; item < PHASE_ITEMS; item++)
            send_sample(random_sample());
      end

      wait_drained;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("trapezoidal_state_variable_filter verification clean");
      else
         $display("trapezoidal_state_variable_filter verification failed");
      $finish;
   end

endmodule

FILE: files.f
src/tsvf_pkg.sv
src/tsvf_if.sv
src/tsvf_mac.sv
src/trapezoidal_state_variable_filter.sv
tb/sv/tsvf_response_checker.sv
tb/sv/trapezoidal_state_variable_filter_tb.sv
